// ===== rtl/lmax3_pkg.sv =====
`default_nettype none

package lmax3_pkg;

    // fixed field widths of the ports
    localparam int PIX_W     = 16;
    localparam int POS_W     = 7;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // frame size after reset
    localparam int FRAME_RST = 128;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS = 2'd0,
        REG_FRAME_COLS = 2'd1
    } t_reg_idx;

    // neighbor offsets: row, column
    localparam int NUM_NB = 8;
    localparam int NB_DR [NUM_NB] = '{-1, 1, 0, 0, -1, -1, 1, 1};
    localparam int NB_DC [NUM_NB] = '{0, 0, -1, 1, -1, 1, -1, 1};

    // pending results of one input, in emission order
    typedef logic [3:0] t_res_mask;

endpackage

`default_nettype wire

// ===== rtl/local_maximum_3x3_top.sv =====
// Flow: a transfer in reaches the line store read the same edge; its first result then
//   passes the window and job registers before it lands in the output register.
// Throughput: one input per cycle while each input yields at most one result and the
//   output accepts; a multi-result input (row end, last row) holds the single emitter.
// Reset: synchronous, active low; clears control, window and sizes (128 x 128). The line
//   store memory is not cleared and needs no clearing pass.
`default_nettype none

module local_maximum_3x3_top
    import lmax3_pkg::*;
#(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 128,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PIX_W-1:0]     i_pixel_value,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [POS_W-1:0]          o_center_row,
    output logic [POS_W-1:0]          o_center_col,
    output logic [PIX_W-1:0]          o_center_value,
    output logic                      o_is_local_max,
    output logic                      o_last_of_run
);

    localparam int DW = DATA_WIDTH;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_COLS);
    localparam int RST_ROWS = (MAX_ROWS < FRAME_RST) ? MAX_ROWS : FRAME_RST;
    localparam int RST_COLS = (MAX_COLS < FRAME_RST) ? MAX_COLS : FRAME_RST;

    // ------------------------------------------------------------------
    // Frame size, kept as last row / last column index
    // ------------------------------------------------------------------
    logic [RW-1:0] r_last_row, n_last_row;
    logic [CW-1:0] r_last_col, n_last_col;
    logic          cfg_hit;

    always_comb begin
        n_last_row = r_last_row;
        n_last_col = r_last_col;
        cfg_hit    = 1'b0;
        if (i_cfg_we && i_cfg_index == REG_FRAME_ROWS) begin
            cfg_hit = 1'b1;
            priority if (i_cfg_data == '0)
                n_last_row = '0;
            else if (32'(i_cfg_data) > 32'(MAX_ROWS))
                n_last_row = RW'(MAX_ROWS - 1);
            else
                n_last_row = RW'(i_cfg_data - 8'd1);
        end
        if (i_cfg_we && i_cfg_index == REG_FRAME_COLS) begin
            cfg_hit = 1'b1;
            priority if (i_cfg_data == '0)
                n_last_col = '0;
            else if (32'(i_cfg_data) > 32'(MAX_COLS))
                n_last_col = CW'(MAX_COLS - 1);
            else
                n_last_col = CW'(i_cfg_data - 8'd1);
        end
    end

    // ------------------------------------------------------------------
    // Handshake control
    //   stage A: input transfer, line store read issued
    //   stage B: read data back, window shift + line store write
    //   job:     results of the item now in the window, while the output accepts one per cycle
    // ------------------------------------------------------------------
    logic      r_b_valid;
    logic      r_job_valid;
    t_res_mask r_job_mask;
    logic      in_fire, b_adv, job_free, out_free, emit_fire, last_emit;
    t_res_mask remaining;

    assign out_free   = !o_out_valid || i_out_ready;
    assign emit_fire  = r_job_valid && out_free;
    assign job_free   = !r_job_valid || (emit_fire && last_emit);
    assign b_adv      = r_b_valid && job_free;
    assign o_in_ready = !r_b_valid || b_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Raster position of the next input
    // ------------------------------------------------------------------
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= RW'(RST_ROWS - 1);
            r_last_col <= CW'(RST_COLS - 1);
            r_row      <= '0;
            r_col      <= '0;
        end else if (cfg_hit) begin
            // a write to either size register restarts the frame
            r_last_row <= n_last_row;
            r_last_col <= n_last_col;
            r_row      <= '0;
            r_col      <= '0;
        end else if (in_fire) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one word per column, {older row, newer row}
    // ------------------------------------------------------------------
    logic [2*DW-1:0] mem [MAX_COLS];
    logic [2*DW-1:0] r_rd;
    logic [2*DW-1:0] r_fwd_data;
    logic            r_fwd_hit;
    logic [DW-1:0]   r_b_px;
    logic [RW-1:0]   r_b_row;
    logic [CW-1:0]   r_b_col;
    logic [2*DW-1:0] rd_word;
    logic [2*DW-1:0] wr_word;
    logic [DW-1:0]   line_a, line_b;

    // write and read of the same column at one edge (one-column frame): bypass
    assign rd_word = r_fwd_hit ? r_fwd_data : r_rd;
    assign line_a  = rd_word[2*DW-1:DW];
    assign line_b  = rd_word[DW-1:0];
    assign wr_word = {line_b, r_b_px};

    always_ff @(posedge i_clk) begin
        if (b_adv)
            mem[r_b_col] <= wr_word;
        if (in_fire)
            r_rd <= mem[r_col];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fwd_hit  <= b_adv && (r_b_col == r_col);
            r_fwd_data <= wr_word;
            r_b_px     <= DW'(i_pixel_value);
            r_b_row    <= r_row;
            r_b_col    <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_b_valid <= 1'b0;
        else if (in_fire)
            r_b_valid <= 1'b1;
        else if (b_adv)
            r_b_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // 3x3 window and result schedule of the item it holds
    // ------------------------------------------------------------------
    logic [DW-1:0] r_win [3][3];
    logic [RW-1:0] r_job_row;
    logic [CW-1:0] r_job_col;
    t_res_mask     b_mask;
    logic          b_top, b_left, b_last_r, b_last_c;

    assign b_top    = (r_b_row != '0);
    assign b_left   = (r_b_col != '0);
    assign b_last_r = (r_b_row == r_last_row);
    assign b_last_c = (r_b_col == r_last_col);
    // bit 0: (R-1,C-1)  bit 1: (R-1,C)  bit 2: (R,C-1)  bit 3: (R,C)
    assign b_mask   = {b_last_r && b_last_c, b_last_r && b_left,
                       b_top && b_last_c, b_top && b_left};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    r_win[r][c] <= '0;
        end else if (b_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_a;
            r_win[1][2] <= line_b;
            r_win[2][2] <= r_b_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_mask  <= '0;
        end else if (b_adv) begin
            r_job_valid <= (b_mask != '0);
            r_job_mask  <= b_mask;
        end else if (emit_fire) begin
            r_job_valid <= !last_emit;
            r_job_mask  <= remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_job_row <= r_b_row;
            r_job_col <= r_b_col;
        end
    end

    // ------------------------------------------------------------------
    // Emitter: judge the lowest pending center against its neighbors
    // ------------------------------------------------------------------
    logic [1:0]    sel;
    logic [1:0]    cen_wr, cen_wc;
    logic [RW-1:0] fr;
    logic [CW-1:0] fc;
    logic [DW-1:0] cen_val;
    logic          up_ok, dn_ok, lf_ok, rt_ok;
    logic          is_max;
    logic [1:0]    nb_wr, nb_wc;
    logic          nb_in;

    always_comb begin
        priority if (r_job_mask[0]) sel = 2'd0;
        else if (r_job_mask[1])     sel = 2'd1;
        else if (r_job_mask[2])     sel = 2'd2;
        else                        sel = 2'd3;
    end

    assign remaining = r_job_mask & ~(t_res_mask'(1) << sel);
    assign last_emit = (remaining == '0);

    assign cen_wr  = sel[1] ? 2'd2 : 2'd1;
    assign cen_wc  = sel[0] ? 2'd2 : 2'd1;
    assign fr      = sel[1] ? r_job_row : r_job_row - 1'b1;
    assign fc      = sel[0] ? r_job_col : r_job_col - 1'b1;
    assign cen_val = r_win[cen_wr][cen_wc];
    assign up_ok   = (fr != '0);
    assign dn_ok   = (fr != r_last_row);
    assign lf_ok   = (fc != '0);
    assign rt_ok   = (fc != r_last_col);

    always_comb begin
        is_max = 1'b1;
        nb_wr  = '0;
        nb_wc  = '0;
        nb_in  = 1'b0;
        for (int k = 0; k < NUM_NB; k++) begin
            nb_wr = 2'(int'(cen_wr) + NB_DR[k]);
            nb_wc = 2'(int'(cen_wc) + NB_DC[k]);
            // inside the window and inside the frame
            nb_in = (int'(cen_wr) + NB_DR[k] <= 2) && (int'(cen_wc) + NB_DC[k] <= 2)
                    && !(NB_DR[k] < 0 && !up_ok) && !(NB_DR[k] > 0 && !dn_ok)
                    && !(NB_DC[k] < 0 && !lf_ok) && !(NB_DC[k] > 0 && !rt_ok);
            if (nb_in && r_win[nb_wr][nb_wc] >= cen_val)
                is_max = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_out_valid <= 1'b0;
        else if (out_free)
            o_out_valid <= r_job_valid;
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            o_center_row   <= POS_W'(fr);
            o_center_col   <= POS_W'(fc);
            o_center_value <= PIX_W'(cen_val);
            o_is_local_max <= is_max;
            o_last_of_run  <= last_emit;
        end
    end

endmodule

`default_nettype wire

// ===== tb/local_maximum_3x3_checker.sv =====
module local_maximum_3x3_checker
    import lmax3_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [PIX_W-1:0]     i_pixel_value,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [POS_W-1:0]     i_center_row,
    input  wire logic [POS_W-1:0]     i_center_col,
    input  wire logic [PIX_W-1:0]     i_center_value,
    input  wire logic                 i_is_local_max,
    input  wire logic                 i_last_of_run,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int LINE_LEN     = 128;
    localparam int ROW_LIM      = 128;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             is_max;
        logic             last_of_run;
    } center_t;

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic [PIX_W-1:0] older_mem [LINE_LEN];
    logic [PIX_W-1:0] newer_mem [LINE_LEN];
    logic [PIX_W-1:0] win [3][3];
    int               row_pos;
    int               col_pos;
    center_t          centers_due [$];
    int               fails;
    int               checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fails        = 0;
        checked      = 0;
    end

    // zero means one, oversize saturates
    function automatic int eff_size(logic [CFG_W-1:0] v, int lim);
        if (v == '0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    // window cell (wr,wc) is frame element (fr,fc); neighbors outside the frame don't count
    function automatic center_t grade_center(int wr, int wc, int fr, int fc,
                                             int rows, int cols);
        center_t c;
        c.row         = fr[POS_W-1:0];
        c.col         = fc[POS_W-1:0];
        c.value       = win[wr][wc];
        c.is_max      = 1'b1;
        c.last_of_run = 1'b0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr == 0 && dc == 0) continue;
                if (fr + dr < 0 || fr + dr >= rows || fc + dc < 0 || fc + dc >= cols) continue;
                if (wr + dr < 0 || wr + dr > 2 || wc + dc < 0 || wc + dc > 2) continue;
                if (win[wr + dr][wc + dc] >= c.value) c.is_max = 1'b0;
            end
        end
        return c;
    endfunction

    task automatic judge_pixel(input logic [PIX_W-1:0] px);
        int               rows;
        int               cols;
        int               r;
        int               c;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        center_t          run [$];
        rows = eff_size(rows_reg, ROW_LIM);
        cols = eff_size(cols_reg, LINE_LEN);
        if (row_pos >= rows || col_pos >= cols) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        above2       = older_mem[c];
        above1       = newer_mem[c];
        older_mem[c] = above1;
        newer_mem[c] = px;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = px;

        if (r >= 1) begin
            if (c >= 1) run.push_back(grade_center(1, 1, r - 1, c - 1, rows, cols));
            if (c == cols - 1) run.push_back(grade_center(1, 2, r - 1, c, rows, cols));
        end
        if (r == rows - 1) begin
            if (c >= 1) run.push_back(grade_center(2, 1, r, c - 1, rows, cols));
            if (c == cols - 1) run.push_back(grade_center(2, 2, r, c, rows, cols));
        end
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[k]) centers_due.push_back(run[k]);

        if (c + 1 >= cols) begin
            col_pos = 0;
            row_pos = (r + 1 >= rows) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_result();
        center_t got;
        center_t want;
        got = {i_center_row, i_center_col, i_center_value, i_is_local_max, i_last_of_run};
        checked++;
        if (centers_due.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("unexpected result: row %0d col %0d value %h max %b last %b",
                         got.row, got.col, got.value, got.is_max, got.last_of_run);
            return;
        end
        want = centers_due.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
            got.is_max !== want.is_max || got.last_of_run !== want.last_of_run) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("mismatch on result %0d:", checked);
                $display("  expected row %0d col %0d value %h max %b last %b",
                         want.row, want.col, want.value, want.is_max, want.last_of_run);
                $display("  actual   row %0d col %0d value %h max %b last %b",
                         got.row, got.col, got.value, got.is_max, got.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = CFG_W'(FRAME_RST);
            cols_reg = CFG_W'(FRAME_RST);
            row_pos  = 0;
            col_pos  = 0;
            for (int k = 0; k < LINE_LEN; k++) begin
                older_mem[k] = '0;
                newer_mem[k] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) win[k][j] = '0;
            end
            centers_due.delete();
        end else begin
            if (i_cfg_we) begin
                // any write to a real register restarts the frame
                if (i_cfg_index == REG_FRAME_ROWS) begin
                    rows_reg = i_cfg_data;
                    row_pos  = 0;
                    col_pos  = 0;
                end else if (i_cfg_index == REG_FRAME_COLS) begin
                    cols_reg = i_cfg_data;
                    row_pos  = 0;
                    col_pos  = 0;
                end
            end
            if (i_in_valid && i_in_ready) judge_pixel(i_pixel_value);
            if (i_out_valid && i_out_ready) check_result();
        end
        o_pending    <= centers_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== tb/local_maximum_3x3_top_tb.sv =====
module local_maximum_3x3_top_tb;
    import lmax3_pkg::*;

    // minimum number of random pixels after the directed part
    localparam int RANDOM_PIXELS  = 500;
    // random phases that always run: covers the tall, hold-off and wide cases
    localparam int MIN_PHASES     = 7;
    // quiet cycles before a register write: covers transfers still in flight
    // when the last transfer produced no result
    localparam int SETTLE_CYCLES  = 10;
    // length of the long output hold-off that backs up the input side
    localparam int HOLD_CYCLES    = 300;
    // cycles with no transfer on either channel before giving up
    localparam int WATCHDOG_LIMIT = 5000;

    // register indexes beyond the two real registers; writes must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // directed 3x3 frames: ties on the top row, a center peak that a corner
    // ties at the extremes; the second is flat apart from one bump
    localparam logic [PIX_W-1:0] PEAK_3X3 [9] = '{
        16'h0005, 16'h0005, 16'h0001,
        16'h0000, 16'hFFFF, 16'h0002,
        16'hFFFF, 16'h0003, 16'hFFFE
    };
    localparam logic [PIX_W-1:0] FLAT_3X3 [9] = '{
        16'h0007, 16'h0007, 16'h0007,
        16'h0007, 16'h0008, 16'h0007,
        16'h0007, 16'h0007, 16'h0007
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic [PIX_W-1:0]     pixel_value   = '0;
    logic                 out_ready     = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [POS_W-1:0]     o_center_row;
    logic [POS_W-1:0]     o_center_col;
    logic [PIX_W-1:0]     o_center_value;
    logic                 o_is_local_max;
    logic                 o_last_of_run;

    int fail_count;
    int pending;
    int results_checked;

    // idling: percent chance per cycle, changed per phase
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;
    int pixels_sent     = 0;
    int phases_run      = 0;

    always #5 i_clk = ~i_clk;

    local_maximum_3x3_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_value  (pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_center_value (o_center_value),
        .o_is_local_max (o_is_local_max),
        .o_last_of_run  (o_last_of_run)
    );

    local_maximum_3x3_checker lmax_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (o_in_ready),
        .i_pixel_value  (pixel_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .i_center_row   (o_center_row),
        .i_center_col   (o_center_col),
        .i_center_value (o_center_value),
        .i_is_local_max (o_is_local_max),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (results_checked)
    );

    // Result side. A requested hold-off drops ready until the hold count runs out;
    // otherwise ready follows the stall percentage of the current phase.
    always @(posedge i_clk) begin
        if (holds_served < holds_requested) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     idle_cycles, pending);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one pixel and hold it until the transfer. Valid stays high into
    // the next call unless a sender gap is drawn, so back-to-back pixels
    // never see valid dropped and raised in the same step.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        pixel_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_FRAME_COLS, cols);
        cfg_we <= 1'b0;
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline
    // empty out anything that produced no result.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    // Small value ranges give lots of ties, which is where strictness matters.
    function automatic logic [PIX_W-1:0] pick_pixel(input int style, input logic [PIX_W-1:0] base);
        case (style)
            0: return PIX_W'($urandom_range(3));
            1: return PIX_W'($urandom);
            2: begin
                case ($urandom_range(3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h7FFF;
                    default: return 16'h8000;
                endcase
            end
            default: return base + PIX_W'($urandom_range(2));
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] rows_w;
        logic [CFG_W-1:0] cols_w;
        logic [PIX_W-1:0] base;
        int               n;
        int               area;
        int               style;
        int               random_start;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed part ----------------
        set_idle(0);

        // reset size is 128x128: row 0 only, nothing is judged yet
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h8000);
        settle();

        // 1x1 frame: every pixel is its own maximum, one result each
        set_frame(8'd1, 8'd1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        settle();

        // zero sizes behave as 1x1
        set_frame(8'd0, 8'd0);
        send_pixel(16'h1234);
        settle();

        // 3x3: corners, edges and the center all judged; extremes and ties
        set_frame(8'd3, 8'd3);
        for (int k = 0; k < 9; k++) send_pixel(PEAK_3X3[k]);

        // second frame wraps in without a write; a spare-index write mid-frame
        // must neither change the size nor restart the frame
        for (int k = 0; k < 4; k++) send_pixel(FLAT_3X3[k]);
        settle();
        write_reg(REG_SPARE_A, 8'hFF);
        write_reg(REG_SPARE_B, 8'h00);
        cfg_we <= 1'b0;
        for (int k = 4; k < 9; k++) send_pixel(FLAT_3X3[k]);
        settle();

        // ---------------- random part ----------------
        // Mostly whole frames with random content; about one phase in four
        // ends with a partial frame that the next write cuts off.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS || phases_run < MIN_PHASES) begin
            set_idle(phases_run % 4);
            style = $urandom_range(3);
            base  = PIX_W'($urandom);
            if (phases_run == 3) begin
                // tall single column, rows saturate at the maximum
                rows_w = 8'd255;
                cols_w = 8'd1;
                n      = 128;
            end else if (phases_run == 6) begin
                // one wide row, columns saturate at the maximum
                rows_w = 8'd1;
                cols_w = 8'd200;
                n      = 128;
            end else if (phases_run == 4) begin
                // long output hold-off while the sender keeps offering
                rows_w = 8'd4;
                cols_w = 8'd8;
                n      = 64;
            end else begin
                rows_w = ($urandom_range(9) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 6));
                cols_w = ($urandom_range(9) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 10));
                area   = ((rows_w == 0) ? 1 : int'(rows_w)) * ((cols_w == 0) ? 1 : int'(cols_w));
                n      = area * $urandom_range(1, 3);
                if ($urandom_range(3) == 0) n += $urandom_range(0, area - 1);
            end

            set_frame(rows_w, cols_w);
            if (phases_run == 4) holds_requested <= holds_requested + 1;
            for (int k = 0; k < n; k++) send_pixel(pick_pixel(style, base));
            settle();
            phases_run++;
        end

        $display("run: %0d pixels, %0d random frame settings, %0d results checked",
                 pixels_sent, phases_run, results_checked);
        $display("covered 1x1 to saturated 128-wide/tall frames, zero sizes, spare writes, "
                 , "partial frames, idle and stall mixes and one long output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("failures: %0d, results still due: %0d", fail_count, pending);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
